// File: sv/bb5_pkg.sv
// Package for the 5x5 edge-normalized box blur: sizes, register indexes,
// controller states, command/status structs and the reciprocal table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package bb5_pkg;

	// Frame limits and derived widths.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
	localparam int LINES      = 4;

	// Fixed field and arithmetic widths.
	localparam int DIM_W       = 11;
	localparam int CMP_W       = 16;
	localparam int SAMPLE_W    = 16;
	localparam int CSUM_W      = 18;
	localparam int WSUM_W      = 20;
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 25;
	localparam int PROD_W      = WSUM_W + RECIP_W;
	localparam int DIV_W       = 5;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [SAMPLE_W-1:0] ONE_Q15   = 16'd32768;
	localparam logic [DIM_W-1:0]    DIM_RESET = 11'd1024;
	localparam logic [DIM_W-1:0]    DIM_MIN   = 11'd3;

	// Register indexes (byte address / 4).
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SEL,
		ST_MUL,
		ST_PUT
	} bb5_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic       take;
		logic       shift;
		logic       sel;
		logic       mul;
		logic       put;
		logic [1:0] idx;
	} bb5_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic [1:0] n_res;
		logic       out_free;
	} bb5_stat_t;

	// ceil(2^25 / d) for d = 1..25; floor(n * m >> 25) equals n / d for n < 2^20.
	function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
		logic [RECIP_W-1:0] m;
		case (d)
			5'd1:    m = 26'd33554432;
			5'd2:    m = 26'd16777216;
			5'd3:    m = 26'd11184811;
			5'd4:    m = 26'd8388608;
			5'd5:    m = 26'd6710887;
			5'd6:    m = 26'd5592406;
			5'd7:    m = 26'd4793491;
			5'd8:    m = 26'd4194304;
			5'd9:    m = 26'd3728271;
			5'd10:   m = 26'd3355444;
			5'd11:   m = 26'd3050403;
			5'd12:   m = 26'd2796203;
			5'd13:   m = 26'd2581111;
			5'd14:   m = 26'd2396746;
			5'd15:   m = 26'd2236963;
			5'd16:   m = 26'd2097152;
			5'd17:   m = 26'd1973791;
			5'd18:   m = 26'd1864136;
			5'd19:   m = 26'd1766023;
			5'd20:   m = 26'd1677722;
			5'd21:   m = 26'd1597831;
			5'd22:   m = 26'd1525202;
			5'd23:   m = 26'd1458889;
			5'd24:   m = 26'd1398102;
			5'd25:   m = 26'd1342178;
			default: m = 26'd0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// File: sv/bb5_ctrl.sv
// Controller state machine of the box blur: accepts one word, sequences the
// column update and then the results of that word one at a time.
// Depends on bb5_pkg.
`default_nettype none

module bb5_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  bb5_pkg::bb5_stat_t stat,
	output bb5_pkg::bb5_cmd_t  cmd
);

	bb5_pkg::bb5_state_t state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [1:0] n_q, n_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bb5_pkg::ST_IDLE;
			idx_q   <= 2'd0;
			n_q     <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			n_q     <= n_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		n_d       = n_q;
		s_tready  = 1'b0;
		cmd       = '0;
		cmd.idx   = idx_q;
		case (state_q)
			bb5_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = bb5_pkg::ST_SUM;
				end
			end
			bb5_pkg::ST_SUM: begin
				cmd.shift = 1'b1;
				idx_d     = 2'd0;
				n_d       = stat.n_res;
				if (stat.n_res == 2'd0) begin
					state_d = bb5_pkg::ST_IDLE;
				end else begin
					state_d = bb5_pkg::ST_SEL;
				end
			end
			bb5_pkg::ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = bb5_pkg::ST_MUL;
			end
			bb5_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = bb5_pkg::ST_PUT;
			end
			bb5_pkg::ST_PUT: begin
				if (stat.out_free) begin
					cmd.put = 1'b1;
					if (idx_q + 2'd1 == n_q) begin
						state_d = bb5_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = bb5_pkg::ST_SEL;
					end
				end
			end
			default: begin
				state_d = bb5_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/bb5_dp.sv
// Datapath of the box blur: position counters, four line stores, five
// column sums, window sum selection, reciprocal divide and output register.
// Depends on bb5_pkg; driven by bb5_ctrl.
`default_nettype none

module bb5_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            restart,
	input  wire [bb5_pkg::DIM_W-1:0]       w_eff,
	input  wire [bb5_pkg::DIM_W-1:0]       h_eff,
	input  wire                            kind,
	input  wire [bb5_pkg::SAMPLE_W-1:0]    ao_value,
	input  bb5_pkg::bb5_cmd_t              cmd,
	output bb5_pkg::bb5_stat_t             stat,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [bb5_pkg::SAMPLE_W-1:0]   m_tdata,
	output logic                           m_tlast
);

	logic [bb5_pkg::CMP_W-1:0] w16, h16;
	logic [bb5_pkg::COL_W-1:0] col_q;
	logic [bb5_pkg::ROW_W-1:0] row_q;
	logic                      col_end, row_end, in_frame;
	logic [bb5_pkg::SAMPLE_W-1:0] v;

	logic [bb5_pkg::SAMPLE_W-1:0] line_mem [bb5_pkg::LINES][bb5_pkg::MAX_WIDTH];
	logic [bb5_pkg::SAMPLE_W-1:0] rd_q [bb5_pkg::LINES];

	logic [bb5_pkg::ROW_W-1:0]    r_s1;
	logic [bb5_pkg::COL_W-1:0]    c_s1;
	logic [bb5_pkg::SAMPLE_W-1:0] v_s1;

	logic [bb5_pkg::CMP_W-1:0]  r16, c16, lo, hi, rows_full;
	logic [bb5_pkg::CSUM_W-1:0] vsum;
	logic [2:0]                 rows;
	logic [bb5_pkg::CSUM_W-1:0] cs_q [5];
	logic [2:0]                 rows_q;
	logic                       last_row_q;

	logic [2:0]                   lim, kmax, cols;
	logic [bb5_pkg::WSUM_W-1:0]   wsum;
	logic [5:0]                   div_full;
	logic [bb5_pkg::WSUM_W-1:0]   wsum_s1;
	logic [bb5_pkg::RECIP_W-1:0]  recip_s1;
	logic                         last_s1;
	logic [bb5_pkg::PROD_W-1:0]   prod_s2;
	logic                         last_s2;
	logic                         out_valid_q;

	assign w16      = bb5_pkg::CMP_W'(w_eff);
	assign h16      = bb5_pkg::CMP_W'(h_eff);
	assign col_end  = (bb5_pkg::CMP_W'(col_q) == w16 - 16'd1);
	assign row_end  = (bb5_pkg::CMP_W'(row_q) == h16 + 16'd1);
	assign in_frame = (bb5_pkg::CMP_W'(row_q) < h16);

	// Drain items count as zero; samples above one saturate.
	always_comb begin
		if (kind) begin
			v = '0;
		end else if (ao_value > bb5_pkg::ONE_Q15) begin
			v = bb5_pkg::ONE_Q15;
		end else begin
			v = ao_value;
		end
	end

	// Raster position of the next word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.take) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + bb5_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + bb5_pkg::COL_W'(1);
			end
		end
	end

	// Line stores: all four read at the column, the current row's line written while in the frame.
	always_ff @(posedge clk) begin
		for (int b = 0; b < bb5_pkg::LINES; b++) begin
			if (cmd.take) begin
				rd_q[b] <= line_mem[b][col_q];
				if (in_frame && row_q[1:0] == 2'(b)) begin
					line_mem[b][col_q] <= v;
				end
			end
		end
	end

	// Item registers for the following steps.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			r_s1 <= row_q;
			c_s1 <= col_q;
			v_s1 <= v;
		end
	end

	assign r16 = bb5_pkg::CMP_W'(r_s1);
	assign c16 = bb5_pkg::CMP_W'(c_s1);

	// Vertical sum over the in-frame rows of the five-row window.
	always_comb begin
		vsum = (r16 < h16) ? bb5_pkg::CSUM_W'(v_s1) : '0;
		for (int k = 1; k <= 4; k++) begin
			if (r16 >= 16'(k) && (r16 < h16 || 16'(k) > r16 - h16)) begin
				vsum = vsum + bb5_pkg::CSUM_W'(rd_q[r_s1[1:0] - 2'(k)]);
			end
		end
		lo        = (r16 >= 16'd4) ? r16 - 16'd4 : 16'd0;
		hi        = (r16 < h16) ? r16 : h16 - 16'd1;
		rows_full = hi - lo + 16'd1;
		rows      = rows_full[2:0];
	end

	// Result count for the word just taken, and whether the output register is free.
	always_comb begin
		stat.n_res = 2'd0;
		if (r16 >= 16'd2 && c16 >= 16'd2) begin
			stat.n_res = (c16 == w16 - 16'd1) ? 2'd3 : 2'd1;
		end
		stat.out_free = !out_valid_q || m_tready;
	end

	// Column sums shift by one column per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 5; k++) begin
				cs_q[k] <= '0;
			end
			rows_q     <= 3'd0;
			last_row_q <= 1'b0;
		end else if (restart) begin
			for (int k = 0; k < 5; k++) begin
				cs_q[k] <= '0;
			end
		end else if (cmd.shift) begin
			for (int k = 1; k < 5; k++) begin
				cs_q[k] <= cs_q[k-1];
			end
			cs_q[0]    <= vsum;
			rows_q     <= rows;
			last_row_q <= (r16 == h16 + 16'd1);
		end
	end

	// Horizontal window of result idx: the newest min(c, 4 - idx) + 1 columns.
	always_comb begin
		lim  = 3'd4 - 3'(cmd.idx);
		kmax = (c16 < 16'(lim)) ? c_s1[2:0] : lim;
		cols = kmax + 3'd1;
		wsum = '0;
		for (int k = 0; k < 5; k++) begin
			if (3'(k) <= kmax) begin
				wsum = wsum + bb5_pkg::WSUM_W'(cs_q[k]);
			end
		end
		div_full = 6'(cols) * 6'(rows_q);
	end

	// Window sum and reciprocal of the divisor.
	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			wsum_s1  <= wsum;
			recip_s1 <= bb5_pkg::recip(div_full[bb5_pkg::DIV_W-1:0]);
			last_s1  <= last_row_q && (cmd.idx == 2'd2);
		end
	end

	// Multiply by the reciprocal.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2 <= bb5_pkg::PROD_W'(wsum_s1) * bb5_pkg::PROD_W'(recip_s1);
			last_s2 <= last_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			m_tdata <= prod_s2[bb5_pkg::RECIP_SHIFT +: bb5_pkg::SAMPLE_W];
			m_tlast <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/box_blur_5x5_edge_normalized_top.sv
// Each result of an input word passes the select, multiply and output steps in order
// after the column update. A new word is taken only once every result of the last one
// (one, or three at the end of a row; some words have none) is loaded, as the steps are shared.
// Reset clears position, column sums and handshake state and sets both sizes
// to 1024; line stores are not cleared. Size writes restart the frame.
// Depends on bb5_pkg, bb5_ctrl and bb5_dp.
`default_nettype none

module box_blur_5x5_edge_normalized_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// Input stream.
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [15:0]                   s_tdata,  // [15:0] ao_value
	input  wire                          s_tuser,  // [0] kind
	// Output stream.
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [15:0]                  m_tdata,  // [15:0] blurred_value
	output logic                         m_tlast,
	// Register port.
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [bb5_pkg::ADDR_W-1:0]    paddr,
	input  wire [bb5_pkg::DATA_W-1:0]    pwdata,
	output logic [bb5_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic [bb5_pkg::DIM_W-1:0] width_q, height_q, w_eff, h_eff;
	logic                      cfg_wr;
	bb5_pkg::bb5_cmd_t         cmd;
	bb5_pkg::bb5_stat_t        stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb5_pkg::DIM_RESET;
			height_q <= bb5_pkg::DIM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == bb5_pkg::REG_WIDTH) begin
				width_q <= pwdata[bb5_pkg::DIM_W-1:0];
			end else begin
				height_q <= pwdata[bb5_pkg::DIM_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == bb5_pkg::REG_HEIGHT) begin
			prdata[bb5_pkg::DIM_W-1:0] = height_q;
		end else begin
			prdata[bb5_pkg::DIM_W-1:0] = width_q;
		end
	end

	// Sizes in use are held to [3, MAX].
	always_comb begin
		if (width_q < bb5_pkg::DIM_MIN) begin
			w_eff = bb5_pkg::DIM_MIN;
		end else if (bb5_pkg::CMP_W'(width_q) > bb5_pkg::CMP_W'(bb5_pkg::MAX_WIDTH)) begin
			w_eff = bb5_pkg::DIM_W'(bb5_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q < bb5_pkg::DIM_MIN) begin
			h_eff = bb5_pkg::DIM_MIN;
		end else if (bb5_pkg::CMP_W'(height_q) > bb5_pkg::CMP_W'(bb5_pkg::MAX_HEIGHT)) begin
			h_eff = bb5_pkg::DIM_W'(bb5_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	bb5_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bb5_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.kind     (s_tuser),
		.ao_value (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// File: sv/bb5_chk.sv
// Port-level checker for the box blur top level, attached with bind.
// Depends on bb5_pkg and the top-level port list.
`default_nettype none

module bb5_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire [15:0]                 s_tdata,
	input wire                        s_tuser,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [15:0]                 m_tdata,
	input wire                        m_tlast,
	input wire                        psel,
	input wire                        penable,
	input wire                        pwrite,
	input wire [bb5_pkg::ADDR_W-1:0]  paddr,
	input wire [bb5_pkg::DATA_W-1:0]  pwdata,
	input wire [bb5_pkg::DATA_W-1:0]  prdata,
	input wire                        pready
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// The block works on one word at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on two cycles in a row");

	// A new result is loaded only while the input side is closed.
	a_out_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while input side was open");

	// A written size reads back.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=>
			(paddr[2] != $past(paddr[2])) || (prdata[10:0] == $past(pwdata[10:0])))
		else $error("size register read back wrong");

endmodule

bind box_blur_5x5_edge_normalized_top bb5_chk u_bb5_chk (.*);

`default_nettype wire

// File: tb/box_blur_5x5_edge_normalized_top_test.sv
// Self-checking testbench for the 5x5 edge-normalized box blur: streams frames
// through the block, predicts every window mean in a scoreboard class and checks them.
// Depends on bb5_pkg and box_blur_5x5_edge_normalized_top.
`default_nettype none

module box_blur_5x5_edge_normalized_top_test;

	localparam int SETTLE     = 20;
	localparam int RANDOM_ITEMS = 85;

	// Scoreboard: its own copy of the blur state and the queue of expected means.
	class blur_scoreboard;
		typedef struct packed {
			logic [15:0] mean;
			logic        last;
		} mean_t;

		logic [10:0] width_reg;
		logic [10:0] height_reg;
		logic [15:0] line_mem [4*bb5_pkg::MAX_WIDTH];
		int          col_sum [5];
		int          col_pos;
		int          row_pos;
		mean_t       expected_means [$];
		int          errors;

		function new();
			width_reg  = bb5_pkg::DIM_RESET;
			height_reg = bb5_pkg::DIM_RESET;
			errors     = 0;
			foreach (line_mem[i]) line_mem[i] = '0;
			restart();
		endfunction

		function int clamp_dim(logic [10:0] v, int top);
			if (v < 3) return 3;
			if (v > top) return top;
			return int'(v);
		endfunction

		function void restart();
			foreach (col_sum[i]) col_sum[i] = 0;
			col_pos = 0;
			row_pos = 0;
		endfunction

		// Any size write restarts the frame.
		function void write_reg(logic idx, logic [31:0] data);
			if (idx == bb5_pkg::REG_WIDTH)
				width_reg = data[10:0];
			else
				height_reg = data[10:0];
			restart();
		endfunction

		// Mean of the in-frame columns around output column x; c is the newest column.
		function int window_mean(int x, int c, int w, int rows);
			int lo, hi, j, k, sum, cols;
			sum  = 0;
			cols = 0;
			lo   = (x >= 2) ? x - 2 : 0;
			hi   = x + 2;
			if (hi > w - 1) hi = w - 1;
			for (j = lo; j <= hi; j++) begin
				k = c - j;
				if (k >= 0 && k < 5) begin
					sum += col_sum[k];
					cols++;
				end
			end
			cols *= rows;
			return (cols != 0) ? sum / cols : 32768;
		endfunction

		// Advance the predictor by one accepted word and queue the means it releases.
		function void note_pixel(logic kind, logic [15:0] ao);
			int w, h, r, c, v, lo, hi, rows, vsum, k, row, first, last_x, x;
			mean_t item;
			w = clamp_dim(width_reg, bb5_pkg::MAX_WIDTH);
			h = clamp_dim(height_reg, bb5_pkg::MAX_HEIGHT);
			if (col_pos >= w || row_pos >= h + 2) restart();
			r = row_pos;
			c = col_pos;
			v = kind ? 0 : int'(ao);
			if (v > 32768) v = 32768;

			// Vertical sum over the in-frame rows of the window.
			lo   = (r >= 4) ? r - 4 : 0;
			hi   = (r < h) ? r : h - 1;
			rows = (hi >= lo) ? hi - lo + 1 : 0;
			vsum = 0;
			for (k = 1; k <= 4; k++) begin
				if (r >= k) begin
					row = r - k;
					if (row >= lo && row <= hi)
						vsum += line_mem[(row % 4) * bb5_pkg::MAX_WIDTH + c];
				end
			end
			if (r < h) begin
				vsum += v;
				line_mem[(r % 4) * bb5_pkg::MAX_WIDTH + c] = 16'(v);
			end
			for (k = 4; k > 0; k--) col_sum[k] = col_sum[k-1];
			col_sum[0] = vsum;

			// One mean per column, three at the end of a row.
			if (r >= 2 && c >= 2) begin
				first  = c - 2;
				last_x = (c == w - 1) ? w - 1 : c - 2;
				for (x = first; x <= last_x; x++) begin
					item.mean = 16'(window_mean(x, c, w, rows));
					item.last = (r == h + 1 && x == w - 1);
					expected_means.push_back(item);
				end
			end

			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h + 2) r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_mean(logic [15:0] mean, logic last);
			mean_t want;
			if (expected_means.size() == 0) begin
				$error("unexpected word: blurred_value %0d, last_of_frame %0b", mean, last);
				errors++;
				return;
			end
			want = expected_means.pop_front();
			if (mean !== want.mean) begin
				$error("blurred_value: expected %0d, actual %0d", want.mean, mean);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_frame: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata  = '0;  // [15:0] ao_value
	logic                          s_tuser  = 1'b0; // [0] kind
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [15:0]                   m_tdata;  // [15:0] blurred_value
	logic                          m_tlast;
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [bb5_pkg::ADDR_W-1:0]    paddr    = '0;
	logic [bb5_pkg::DATA_W-1:0]    pwdata   = '0;
	logic [bb5_pkg::DATA_W-1:0]    prdata;
	logic                          pready;

	logic           steady = 1'b0;
	blur_scoreboard sb = new();

	box_blur_5x5_edge_normalized_top dut (.*);

	always #5 clk = ~clk;

	// Output side stalls at random unless a steady stretch is running.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 38);
	end

	// Accepted words on both sides feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_pixel(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_mean(m_tdata, m_tlast);
	end

	// Present one input word, with random idle cycles ahead of it.
	task automatic send_pixel(input logic kind, input logic [15:0] value);
		if (!steady) begin
			while ($urandom_range(99) < 38) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Register write with random junk above the 11 size bits.
	task automatic write_size(input logic idx, input logic [10:0] size);
		logic [31:0] data;
		data    = ($urandom() & 32'hFFFF_F800) | 32'(size);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the input until every expected mean is out, then let the pipe settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_means.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] random_sample();
		case ($urandom_range(9))
			0, 1:    return 16'd0;
			2, 3:    return 16'd32768;
			4:       return 16'($urandom_range(65535, 32769));
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	initial begin
		int random_items, w_val, h_val, wd, hd, frames, n, i, f;
		logic kind;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame; both sizes written below the minimum.
		write_size(bb5_pkg::REG_WIDTH, 11'd0);
		write_size(bb5_pkg::REG_HEIGHT, 11'd2);
		// Frame rows: saturation above one, and a drain word inside the frame.
		send_pixel(1'b0, 16'hFFFF);
		send_pixel(1'b0, 16'h8000);
		send_pixel(1'b0, 16'h0000);
		send_pixel(1'b0, 16'h8001);
		send_pixel(1'b1, 16'hFFFF);
		send_pixel(1'b0, 16'h7FFF);
		send_pixel(1'b0, 16'h5555);
		send_pixel(1'b0, 16'hAAAA);
		send_pixel(1'b0, 16'h8000);
		// Drain rows, with frame samples mixed in that must be ignored.
		send_pixel(1'b1, 16'h0000);
		send_pixel(1'b0, 16'h1234);
		send_pixel(1'b1, 16'hFFFF);
		send_pixel(1'b1, 16'h0000);
		send_pixel(1'b1, 16'h0000);
		send_pixel(1'b0, 16'hFFFF);
		// Extra words start a new frame, which the next size write cuts short.
		send_pixel(1'b0, 16'h8000);
		send_pixel(1'b0, 16'h0001);
		send_pixel(1'b0, 16'h4000);
		wait_drained();

		// Sizes written above the maximum; a few words of the widest first row
		// must release nothing.
		write_size(bb5_pkg::REG_WIDTH, 11'd2047);
		write_size(bb5_pkg::REG_HEIGHT, 11'd2047);
		for (i = 0; i < 12; i++)
			send_pixel($urandom_range(15) == 0, random_sample());
		wait_drained();

		// Random phases: mostly well-formed frames, some flipped kinds and cut frames.
		// The first phases run with no idling on either side.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			steady <= (random_items < 30);
			case ($urandom_range(5))
				0:       w_val = $urandom_range(2);
				1:       w_val = $urandom_range(16, 9);
				default: w_val = $urandom_range(8, 3);
			endcase
			h_val = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(5, 3);
			write_size(bb5_pkg::REG_WIDTH, 11'(w_val));
			write_size(bb5_pkg::REG_HEIGHT, 11'(h_val));
			wd = (w_val < 3) ? 3 : w_val;
			hd = (h_val < 3) ? 3 : h_val;
			frames = $urandom_range(2, 1);
			for (f = 0; f < frames; f++) begin
				for (i = 0; i < wd * (hd + 2); i++) begin
					kind = (i >= wd * hd);
					if ($urandom_range(9) == 0) kind = ~kind;
					send_pixel(kind, random_sample());
					random_items++;
				end
			end
			// A cut frame, restarted by the next size write.
			if ($urandom_range(3) == 0) begin
				n = $urandom_range(wd * hd, 1);
				for (i = 0; i < n; i++) begin
					send_pixel($urandom_range(1), random_sample());
					random_items++;
				end
			end
			wait_drained();
		end

		wait_drained();
		if (sb.errors == 0 && sb.expected_means.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
